@@ hw/rtl/dtmr_pkg.sv @@
package dtmr_pkg;

	// default configuration
	localparam int CHANNEL_COUNT_DEF = 2;
	localparam int COUNTER_BITS_DEF = 56;
	localparam int PSEL_BITS_DEF = 3;

	// item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// register map
	localparam logic [3:0] REG_IRQ_EN = 4'd0;
	localparam logic [3:0] REG_IRQ_STAT = 4'd1;
	localparam logic [3:0] REG_CH0_BASE = 4'd2;
	localparam logic [3:0] REG_CH1_BASE = 4'd7;
	localparam logic [3:0] REG_CH2_BASE = 4'd12;

	// per-channel register offsets
	localparam logic [2:0] SUB_CTRL = 3'd0;
	localparam logic [2:0] SUB_INTV_LO = 3'd1;
	localparam logic [2:0] SUB_INTV_HI = 3'd2;
	localparam logic [2:0] SUB_CUR_LO = 3'd3;
	localparam logic [2:0] SUB_CUR_HI = 3'd4;

	// control word bits
	localparam int CTRL_EN_BIT = 0;
	localparam int CTRL_RELOAD_BIT = 1;
	localparam int CTRL_PSEL_LSB = 4;
	localparam int CTRL_SINGLE_BIT = 7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_line;
	} rsp_t;

	// commands from the top level to one channel
	typedef struct packed {
		logic        tick;
		logic        wr_ctrl;
		logic        wr_intv_lo;
		logic        wr_intv_hi;
		logic [31:0] wdata;
	} chan_cmd_t;

	typedef struct packed {
		logic       is_chan;
		logic [1:0] chan;
		logic [2:0] sub;
	} reg_dec_t;

	// split a register index into channel and offset, five registers per channel
	function automatic reg_dec_t dtmr_decode(input logic [3:0] idx);
		reg_dec_t d;
		d.is_chan = 1'b1;
		if (idx >= REG_CH2_BASE) begin
			d.chan = 2'd2;
			d.sub = 3'(idx - REG_CH2_BASE);
		end else if (idx >= REG_CH1_BASE) begin
			d.chan = 2'd1;
			d.sub = 3'(idx - REG_CH1_BASE);
		end else if (idx >= REG_CH0_BASE) begin
			d.chan = 2'd0;
			d.sub = 3'(idx - REG_CH0_BASE);
		end else begin
			d.is_chan = 1'b0;
			d.chan = 2'd0;
			d.sub = SUB_CTRL;
		end
		return d;
	endfunction

endpackage

@@ hw/rtl/dtmr_chan.sv @@
module dtmr_chan
	import dtmr_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int PSEL_BITS = PSEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  chan_cmd_t               cmd,
	output logic [7:0]              ctrl,
	output logic [COUNTER_BITS-1:0] interval,
	output logic [COUNTER_BITS-1:0] count,
	output logic                    expire
);

	localparam int PRE_BITS = (1 << PSEL_BITS) - 1;

	logic [7:0]              ctrl_q, ctrl_d;
	logic [COUNTER_BITS-1:0] intv_q, intv_d;
	logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
	logic [PRE_BITS-1:0]     pre_q, pre_d;
	logic [PSEL_BITS-1:0]    sel;
	logic [PRE_BITS-1:0]     pmask;
	logic [PRE_BITS-1:0]     pre_inc;

	// prescaler wraps at 2^sel
	assign sel = ctrl_q[CTRL_PSEL_LSB +: PSEL_BITS];
	assign pmask = ~({PRE_BITS{1'b1}} << sel);
	assign pre_inc = (pre_q + PRE_BITS'(1)) & pmask;

	// next state for tick and register writes
	always_comb begin
		ctrl_d = ctrl_q;
		intv_d = intv_q;
		cnt_d = cnt_q;
		pre_d = pre_q;
		expire = 1'b0;
		if (cmd.tick && ctrl_q[CTRL_EN_BIT]) begin
			pre_d = pre_inc;
			if (pre_inc == '0) begin
				if (cnt_q > COUNTER_BITS'(1)) begin
					cnt_d = cnt_q - COUNTER_BITS'(1);
				end else begin
					expire = 1'b1;
					if (ctrl_q[CTRL_SINGLE_BIT]) begin
						cnt_d = '0;
						ctrl_d[CTRL_EN_BIT] = 1'b0;
					end else begin
						cnt_d = intv_q;
					end
				end
			end
		end
		if (cmd.wr_ctrl) begin
			ctrl_d = cmd.wdata[7:0];
			ctrl_d[CTRL_RELOAD_BIT] = 1'b0;
			if (cmd.wdata[CTRL_RELOAD_BIT]) begin
				cnt_d = intv_q;
				pre_d = '0;
			end
		end
		if (cmd.wr_intv_lo) begin
			intv_d[31:0] = cmd.wdata;
		end
		if (cmd.wr_intv_hi) begin
			intv_d[COUNTER_BITS-1:32] = cmd.wdata[COUNTER_BITS-33:0];
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			intv_q <= '0;
			cnt_q <= '0;
			pre_q <= '0;
		end else begin
			ctrl_q <= ctrl_d;
			intv_q <= intv_d;
			cnt_q <= cnt_d;
			pre_q <= pre_d;
		end
	end

	assign ctrl = ctrl_q;
	assign interval = intv_q;
	assign count = cnt_q;

endmodule

@@ hw/rtl/dual_56bit_down_timer.sv @@
// flow: an accepted word waits in the input register until the result
//   register is free or draining, then its result is registered there
// throughput: one word per cycle via both registers while rsp_ready is high
// reset: arst_n clears all timer state, irq registers and both valid flags
module dual_56bit_down_timer
	import dtmr_pkg::*;
#(
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int PSEL_BITS = PSEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic                     valid_s1;
	req_t                     item_s1;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	logic                     advance;
	reg_dec_t                 dec;
	logic                     is_write;
	logic [CHANNEL_COUNT-1:0] en_q, en_d;
	logic [CHANNEL_COUNT-1:0] stat_q, stat_d;
	logic [CHANNEL_COUNT-1:0] expire_v;
	logic [CHANNEL_COUNT-1:0] hit_v;
	logic [7:0]               ctrl_v [CHANNEL_COUNT];
	logic [COUNTER_BITS-1:0]  intv_v [CHANNEL_COUNT];
	logic [COUNTER_BITS-1:0]  cnt_v [CHANNEL_COUNT];
	logic [31:0]              rd;

	// handshake: the input stage drains into the result register
	assign advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	assign dec = dtmr_decode(item_s1.reg_index);
	assign is_write = advance && (item_s1.kind == KIND_WRITE);

	// channels
	for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
		chan_cmd_t cmd;

		assign hit_v[c] = dec.is_chan && (int'(dec.chan) == c);
		assign cmd.tick = advance && (item_s1.kind == KIND_TICK);
		assign cmd.wr_ctrl = is_write && hit_v[c] && (dec.sub == SUB_CTRL);
		assign cmd.wr_intv_lo = is_write && hit_v[c] && (dec.sub == SUB_INTV_LO);
		assign cmd.wr_intv_hi = is_write && hit_v[c] && (dec.sub == SUB_INTV_HI);
		assign cmd.wdata = item_s1.write_data;

		dtmr_chan #(
			.COUNTER_BITS(COUNTER_BITS),
			.PSEL_BITS(PSEL_BITS)
		) u_chan (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.ctrl(ctrl_v[c]),
			.interval(intv_v[c]),
			.count(cnt_v[c]),
			.expire(expire_v[c])
		);
	end

	// irq enable and write-1-to-clear status
	always_comb begin
		en_d = en_q;
		stat_d = stat_q | expire_v;
		if (is_write && (item_s1.reg_index == REG_IRQ_EN)) begin
			en_d = item_s1.write_data[CHANNEL_COUNT-1:0];
		end
		if (is_write && (item_s1.reg_index == REG_IRQ_STAT)) begin
			stat_d = stat_q & ~item_s1.write_data[CHANNEL_COUNT-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			stat_q <= '0;
		end else begin
			en_q <= en_d;
			stat_q <= stat_d;
		end
	end

	// read mux
	always_comb begin
		rd = '0;
		if (item_s1.kind == KIND_READ) begin
			if (item_s1.reg_index == REG_IRQ_EN) begin
				rd[CHANNEL_COUNT-1:0] = en_q;
			end else if (item_s1.reg_index == REG_IRQ_STAT) begin
				rd[CHANNEL_COUNT-1:0] = stat_q;
			end else begin
				for (int c = 0; c < CHANNEL_COUNT; c++) begin
					if (hit_v[c]) begin
						case (dec.sub)
							SUB_CTRL: begin
								rd[7:0] = ctrl_v[c];
							end
							SUB_INTV_LO: begin
								rd = intv_v[c][31:0];
							end
							SUB_INTV_HI: begin
								rd[COUNTER_BITS-33:0] = intv_v[c][COUNTER_BITS-1:32];
							end
							SUB_CUR_LO: begin
								rd = cnt_v[c][31:0];
							end
							SUB_CUR_HI: begin
								rd[COUNTER_BITS-33:0] = cnt_v[c][COUNTER_BITS-1:32];
							end
							default: begin
								rd = '0;
							end
						endcase
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data <= rd;
			rsp_q.irq_line <= |(stat_d & en_d);
		end
	end

endmodule

@@ tb/sv/dtmr_response_checker.sv @@
`timescale 1ns / 100ps

module dtmr_response_checker
	import dtmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   checked_count,
	output int   expiry_count
);

	localparam int NCH = CHANNEL_COUNT_DEF;
	localparam int CNT_W = COUNTER_BITS_DEF;
	localparam int HI_W = CNT_W - 32;
	localparam int PCNT_W = (1 << PSEL_BITS_DEF) - 1;
	localparam int REGS_PER_CH = 5;

	// shadow copy of the timer registers
	logic [7:0]        tmr_ctrl [NCH];
	logic [CNT_W-1:0]  tmr_intv [NCH];
	logic [CNT_W-1:0]  tmr_cur [NCH];
	logic [PCNT_W-1:0] tmr_pcnt [NCH];
	logic [NCH-1:0]    tmr_irq_en;
	logic [NCH-1:0]    tmr_irq_stat;

	rsp_t expected_rsps[$];
	rsp_t exp_rsp;

	// map a register index onto channel and offset, 0 when no such channel
	function automatic bit locate_reg(input logic [3:0] idx, output int c,
			output logic [2:0] sub);
		c = 0;
		sub = SUB_CTRL;
		for (int k = 0; k < NCH; k++) begin
			if (idx >= REG_CH0_BASE + REGS_PER_CH * k &&
					idx < REG_CH0_BASE + REGS_PER_CH * (k + 1)) begin
				c = k;
				sub = 3'(idx - REG_CH0_BASE - REGS_PER_CH * k);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// one base tick for one channel: prescaler, count down, expiry
	task automatic advance_channel(input int c);
		int sel;
		logic [PCNT_W-1:0] pmask;
		if (!tmr_ctrl[c][CTRL_EN_BIT])
			return;
		sel = int'(tmr_ctrl[c][CTRL_PSEL_LSB +: PSEL_BITS_DEF]);
		pmask = PCNT_W'((1 << sel) - 1);
		tmr_pcnt[c] = (tmr_pcnt[c] + 1'b1) & pmask;
		if (tmr_pcnt[c] != '0)
			return;
		if (tmr_cur[c] > 1) begin
			tmr_cur[c] = tmr_cur[c] - 1'b1;
			return;
		end
		// reaching zero, or counting while already at zero
		tmr_cur[c] = '0;
		tmr_irq_stat[c] = 1'b1;
		expiry_count++;
		if (tmr_ctrl[c][CTRL_SINGLE_BIT])
			tmr_ctrl[c][CTRL_EN_BIT] = 1'b0;
		else
			tmr_cur[c] = tmr_intv[c];
	endtask

	task automatic register_write(input logic [3:0] idx, input logic [31:0] data);
		int c;
		logic [2:0] sub;
		if (idx == REG_IRQ_EN) begin
			tmr_irq_en = data[NCH-1:0];
		end else if (idx == REG_IRQ_STAT) begin
			// write one to clear
			tmr_irq_stat &= ~data[NCH-1:0];
		end else if (locate_reg(idx, c, sub)) begin
			case (sub)
				SUB_CTRL: begin
					tmr_ctrl[c] = data[7:0];
					tmr_ctrl[c][CTRL_RELOAD_BIT] = 1'b0;
					if (data[CTRL_RELOAD_BIT]) begin
						tmr_cur[c] = tmr_intv[c];
						tmr_pcnt[c] = '0;
					end
				end
				SUB_INTV_LO: tmr_intv[c][31:0] = data;
				SUB_INTV_HI: tmr_intv[c][CNT_W-1:32] = data[HI_W-1:0];
				default: ;
			endcase
		end
	endtask

	function automatic logic [31:0] register_read(input logic [3:0] idx);
		logic [31:0] rd;
		int c;
		logic [2:0] sub;
		rd = '0;
		if (idx == REG_IRQ_EN) begin
			rd[NCH-1:0] = tmr_irq_en;
		end else if (idx == REG_IRQ_STAT) begin
			rd[NCH-1:0] = tmr_irq_stat;
		end else if (locate_reg(idx, c, sub)) begin
			case (sub)
				SUB_CTRL: rd[7:0] = tmr_ctrl[c];
				SUB_INTV_LO: rd = tmr_intv[c][31:0];
				SUB_INTV_HI: rd[HI_W-1:0] = tmr_intv[c][CNT_W-1:32];
				SUB_CUR_LO: rd = tmr_cur[c][31:0];
				SUB_CUR_HI: rd[HI_W-1:0] = tmr_cur[c][CNT_W-1:32];
				default: ;
			endcase
		end
		return rd;
	endfunction

	// apply one request word to the shadow state and form its response
	task automatic predict_timer_word(input req_t w, output rsp_t r);
		r.read_data = '0;
		case (w.kind)
			KIND_TICK: begin
				for (int c = 0; c < NCH; c++)
					advance_channel(c);
			end
			KIND_WRITE: register_write(w.reg_index, w.write_data);
			KIND_READ: r.read_data = register_read(w.reg_index);
			default: ;
		endcase
		r.irq_line = |(tmr_irq_stat & tmr_irq_en);
	endtask

	// watch both channels, predict on accept, compare on delivery
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				tmr_ctrl[c] = '0;
				tmr_intv[c] = '0;
				tmr_cur[c] = '0;
				tmr_pcnt[c] = '0;
			end
			tmr_irq_en = '0;
			tmr_irq_stat = '0;
			expected_rsps.delete();
			fail_count = 0;
			checked_count = 0;
			expiry_count = 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_timer_word(req, exp_rsp);
				expected_rsps.push_back(exp_rsp);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected response word: read_data %h irq_line %b",
							rsp.read_data, rsp.irq_line);
					fail_count++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.read_data !== exp_rsp.read_data ||
							rsp.irq_line !== exp_rsp.irq_line) begin
						if (fail_count < 10)
							$display("mismatch word %0d: data exp %h got %h, irq exp %b got %b",
								checked_count, exp_rsp.read_data, rsp.read_data,
								exp_rsp.irq_line, rsp.irq_line);
						fail_count++;
					end
					checked_count++;
				end
			end
		end
		pending = expected_rsps.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import dtmr_pkg::*;

	// the one kind that the block does nothing with
	localparam logic [1:0] KIND_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_count;
	int pending;
	int checked_count;
	int expiry_count;

	int send_idle_pct;
	int recv_idle_pct;
	int stall_requests;
	int stall_served = 0;
	int stall_left = 0;
	int words_sent;
	int n_tick;
	int n_write;
	int n_read;
	int n_other;

	dual_56bit_down_timer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	dtmr_response_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.checked_count(checked_count),
		.expiry_count(expiry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// response side: random back-pressure plus long hold-offs on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_requests;
			stall_left <= 79;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// offer one request word, with random idle cycles ahead of it
	task automatic send_word(input logic [1:0] kind, input logic [3:0] idx,
			input logic [31:0] data);
		req_t w;
		w.kind = kind;
		w.reg_index = idx;
		w.write_data = data;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		case (kind)
			KIND_TICK: n_tick++;
			KIND_WRITE: n_write++;
			KIND_READ: n_read++;
			default: n_other++;
		endcase
	endtask

	// stop offering and wait until every predicted response has come back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly channel programs followed by ticks, the rest random words
	task automatic run_random_phase(input int target);
		int start;
		int c;
		int len;
		int psel;
		logic [3:0] base;
		logic [31:0] ctl;
		bit stalled;
		bit paused;
		start = words_sent;
		stalled = 1'b0;
		paused = 1'b0;
		while (words_sent - start < target) begin
			if (!stalled && words_sent - start > target / 3) begin
				stall_requests++;
				stalled = 1'b1;
			end
			if (!paused && words_sent - start > 2 * target / 3) begin
				drain_responses();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 7) begin
				c = $urandom_range(0, 1);
				base = c ? REG_CH1_BASE : REG_CH0_BASE;
				// short intervals so expiries happen, now and then a huge one
				if ($urandom_range(0, 7) == 0) begin
					send_word(KIND_WRITE, base + SUB_INTV_LO, $urandom);
					send_word(KIND_WRITE, base + SUB_INTV_HI, $urandom);
				end else begin
					send_word(KIND_WRITE, base + SUB_INTV_LO, $urandom_range(0, 12));
					send_word(KIND_WRITE, base + SUB_INTV_HI, 32'h0);
				end
				psel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
					$urandom_range(0, 1);
				ctl = $urandom;
				ctl[CTRL_EN_BIT] = 1'b1;
				ctl[CTRL_RELOAD_BIT] = 1'b1;
				ctl[CTRL_PSEL_LSB +: PSEL_BITS_DEF] = PSEL_BITS_DEF'(psel);
				send_word(KIND_WRITE, base + SUB_CTRL, ctl);
				len = $urandom_range(4, 40);
				repeat (len) begin
					case ($urandom_range(0, 9))
						0: send_word(KIND_READ, base + 4'($urandom_range(0, 4)), $urandom);
						1: send_word(KIND_READ, REG_IRQ_STAT, $urandom);
						2: send_word(KIND_WRITE, REG_IRQ_STAT, $urandom);
						3: begin
							if ($urandom_range(0, 2) == 0)
								send_word(KIND_WRITE, REG_IRQ_EN, $urandom);
							else
								send_word(KIND_READ, base + SUB_CTRL, $urandom);
						end
						default: send_word(KIND_TICK, 4'($urandom), $urandom);
					endcase
				end
			end else begin
				send_word(2'($urandom), 4'($urandom), $urandom);
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		stall_requests = 0;
		words_sent = 0;
		n_tick = 0;
		n_write = 0;
		n_read = 0;
		n_other = 0;
		send_idle_pct = 26;
		recv_idle_pct = 81;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// enable register keeps only the channel bits
		send_word(KIND_WRITE, REG_IRQ_EN, 32'hFFFF_FFFF);
		send_word(KIND_READ, REG_IRQ_EN, 32'h0);
		// largest interval, high half trimmed
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_INTV_LO, 32'hFFFF_FFFF);
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_INTV_HI, 32'hFFFF_FFFF);
		send_word(KIND_READ, REG_CH0_BASE + SUB_INTV_HI, 32'h0);
		// reload while stopped
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_CTRL, 32'h0000_0002);
		send_word(KIND_READ, REG_CH0_BASE + SUB_CUR_HI, 32'h0);
		// current count is read-only
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_CUR_LO, 32'h0);
		send_word(KIND_READ, REG_CH0_BASE + SUB_CUR_LO, 32'h0);
		// stopped channel holds on ticks
		send_word(KIND_TICK, 4'h0, 32'h0);
		send_word(KIND_READ, REG_CH0_BASE + SUB_CUR_LO, 32'h0);
		// zero interval, single-shot: fires on the first tick and stops
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_INTV_LO, 32'h0);
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_INTV_HI, 32'h0);
		send_word(KIND_WRITE, REG_CH0_BASE + SUB_CTRL, 32'h0000_0083);
		send_word(KIND_TICK, 4'hF, 32'hFFFF_FFFF);
		send_word(KIND_READ, REG_CH0_BASE + SUB_CTRL, 32'h0);
		send_word(KIND_READ, REG_IRQ_STAT, 32'h0);
		// status: zeros keep, ones clear
		send_word(KIND_WRITE, REG_IRQ_STAT, 32'h0);
		send_word(KIND_WRITE, REG_IRQ_STAT, 32'hFFFF_FFFF);
		// spare ctrl bits kept, slowest prescaler, periodic
		send_word(KIND_WRITE, REG_CH1_BASE + SUB_CTRL, 32'hFFFF_FF7F);
		send_word(KIND_READ, REG_CH1_BASE + SUB_CTRL, 32'h0);
		// indexes past the last channel
		send_word(KIND_WRITE, REG_CH2_BASE + SUB_INTV_HI, 32'hFFFF_FFFF);
		send_word(KIND_READ, REG_CH2_BASE + SUB_CUR_LO, 32'h0);
		// unused kind leaves everything alone
		send_word(KIND_NONE, REG_IRQ_EN, 32'hFFFF_FFFF);
		send_word(KIND_READ, REG_IRQ_EN, 32'h0);

		run_random_phase(550);
		send_idle_pct = 81;
		recv_idle_pct = 26;
		run_random_phase(550);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(550);

		drain_responses();
		repeat (8) @(posedge clk);
		@(negedge clk);
		$display("%0d words sent (%0d ticks, %0d writes, %0d reads, %0d unused kind)",
			words_sent, n_tick, n_write, n_read, n_other);
		$display("%0d responses checked, %0d counter expiries, three idle mixes, %s",
			checked_count, expiry_count, "long response hold-offs and drains");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/dtmr_pkg.sv
hw/rtl/dtmr_chan.sv
hw/rtl/dual_56bit_down_timer.sv
tb/sv/dtmr_response_checker.sv
tb/sv/tb_top.sv
